// File: sv/fmma_pkg.sv
package fmma_pkg;

  localparam int unsigned MaxDim = 32;
  localparam int unsigned IdxW = $clog2(MaxDim);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned SizeW = 6;
  localparam int unsigned DimW = $clog2(MaxDim + 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam logic [31:0] QNaN = 32'h7FC0_0000;

  typedef enum logic [2:0] {
    CmdWriteA = 3'd0,
    CmdWriteB = 3'd1,
    CmdWriteC = 3'd2,
    CmdMac = 3'd3,
    CmdReadC = 3'd4,
    CmdNone = 3'd5
  } cmd_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    cmd_e cmd;
    logic oor;
    logic [AddrW-1:0] addr;
    logic [DimW-1:0] dim;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic sign;
    logic [7:0] exp;
    logic [22:0] man;
  } fp_t;

  function automatic logic [31:0] canon(input logic [31:0] x);
    logic [31:0] r;
    r = x;
    if (x[30:23] == 8'hFF && x[22:0] != 23'd0) r = QNaN;
    return r;
  endfunction

endpackage

// File: sv/fmma_front.sv
module fmma_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         in_op_i,
  input  logic [4:0]         in_row_i,
  input  logic [4:0]         in_col_i,
  input  logic [31:0]        in_value_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output fmma_pkg::cmd_t     q_cmd_o
);
  import fmma_pkg::*;

  logic [SizeW-1:0] size_q;
  logic [DimW-1:0] dim;
  cmd_t entry;
  cmd_t fifo_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0] cnt_q;
  logic push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(MaxDim);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(size_q) > MaxDim) dim = DimW'(MaxDim);
    else dim = DimW'(size_q);
  end

  always_comb begin
    entry.addr = {in_row_i[IdxW-1:0], in_col_i[IdxW-1:0]};
    entry.dim = dim;
    entry.value = in_value_i;
    entry.oor = 1'b0;
    case (in_op_i)
      3'd0: entry.cmd = CmdWriteA;
      3'd1: entry.cmd = CmdWriteB;
      3'd2: entry.cmd = CmdWriteC;
      3'd3: entry.cmd = CmdMac;
      3'd4: entry.cmd = CmdReadC;
      default: entry.cmd = CmdNone;
    endcase
    if (entry.cmd != CmdMac && entry.cmd != CmdNone &&
        (DimW'(in_row_i) >= dim || DimW'(in_col_i) >= dim)) begin
      entry.oor = 1'b1;
    end
  end

  assign in_ready_o = (cnt_q != (QueuePtrW+1)'(QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= entry;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overfull");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dim <= DimW'(MaxDim)) else $error("size not clamped");
endmodule

// File: sv/fmma_fpmul.sv
module fmma_fpmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  import fmma_pkg::*;

  // Stage one: unpack and multiply significands; stage two: normalise and round.
  logic [47:0] prod_d, prod_q;
  logic        sgn_d, sgn_q, spec_d, spec_q;
  logic [31:0] spec_val_d, spec_val_q;
  logic signed [10:0] exp_d, exp_q;
  logic [5:0] lz_d, lz_q;
  logic [23:0] ma, mb;
  logic [7:0] ea, eb;
  logic [4:0] lza, lzb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  function automatic logic [4:0] lz24(input logic [23:0] m);
    logic [4:0] n;
    logic done;
    n = 5'd0;
    done = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!done && m[i]) done = 1'b1;
      else if (!done) n = n + 5'd1;
    end
    return n;
  endfunction

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    a_nan = ea == 8'hFF && a_i[22:0] != 0;
    b_nan = eb == 8'hFF && b_i[22:0] != 0;
    a_inf = ea == 8'hFF && a_i[22:0] == 0;
    b_inf = eb == 8'hFF && b_i[22:0] == 0;
    a_zero = ea == 0 && a_i[22:0] == 0;
    b_zero = eb == 0 && b_i[22:0] == 0;
    ma = {ea != 0, a_i[22:0]};
    mb = {eb != 0, b_i[22:0]};
    lza = lz24(ma);
    lzb = lz24(mb);
    sgn_d = a_i[31] ^ b_i[31];
    prod_d = ma * mb;
    // Biased exponent of bit 46 of the product.
    exp_d = 11'(signed'({3'b0, (ea == 0) ? 8'd1 : ea})) +
            11'(signed'({3'b0, (eb == 0) ? 8'd1 : eb})) - 11'sd127;
    lz_d = 6'(lza) + 6'(lzb);
    spec_d = 1'b1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) spec_val_d = QNaN;
    else if (a_inf || b_inf) spec_val_d = {sgn_d, 8'hFF, 23'd0};
    else if (a_zero || b_zero) spec_val_d = {sgn_d, 31'd0};
    else begin
      spec_d = 1'b0;
      spec_val_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sgn_q <= sgn_d;
    spec_q <= spec_d;
    spec_val_q <= spec_val_d;
    exp_q <= exp_d;
    lz_q <= lz_d;
  end

  logic [47:0] norm;
  logic signed [10:0] e;
  logic [23:0] mant;
  logic g, st, rup;
  logic [24:0] mr;
  logic [47:0] dn;
  logic [8:0] rs;

  always_comb begin
    // After removing the input leading zeros the product leads at bit 47 or bit 46.
    norm = prod_q << lz_q;
    e = exp_q - 11'(signed'({5'd0, lz_q}));
    if (norm[47]) begin
      e = e + 11'sd1;
    end else begin
      norm = norm << 1;
    end
    // norm[47] is the leading one, e is its biased exponent.
    dn = norm;
    rs = 9'd0;
    if (e < 11'sd1) begin
      rs = 9'(11'sd1 - e);
      if (rs > 9'd48) dn = '0;
      else dn = norm >> rs;
      e = 11'sd0;
    end
    if (e < 11'sd1 && rs > 9'd48) st = |norm;
    else st = |dn[22:0] || (e == 0 && rs <= 9'd48 && |(norm & ~(dn << rs)));
    mant = dn[47:24];
    g = dn[23];
    rup = g && (st || mant[0]);
    mr = {1'b0, mant} + 25'(rup);
    p_o = '0;
    if (spec_q) p_o = spec_val_q;
    else if (e == 0) begin
      p_o = {sgn_q, 8'(mr[23]), mr[22:0]};
    end else begin
      if (mr[24]) begin
        e = e + 11'sd1;
        mr = mr >> 1;
      end
      if (e >= 11'sd255) p_o = {sgn_q, 8'hFF, 23'd0};
      else p_o = {sgn_q, e[7:0], mr[22:0]};
    end
  end
endmodule

// File: sv/fmma_fpadd.sv
module fmma_fpadd (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);
  import fmma_pkg::*;

  // Stage one aligns and adds; stage two normalises and rounds.
  logic a_nan, b_nan, a_inf, b_inf;
  logic [7:0] ea, eb, el;
  logic [26:0] ma, mb, mbig, msml;
  logic sbig, ssml, swap;
  logic [7:0] d;
  logic [26:0] al;
  logic stk;
  logic [27:0] sum_d, sum_q;
  logic sgn_d, sgn_q, spec_d, spec_q, zero_d, zero_q;
  logic [31:0] spec_val_d, spec_val_q;
  logic [7:0] exp_d, exp_q;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    a_nan = ea == 8'hFF && a_i[22:0] != 0;
    b_nan = eb == 8'hFF && b_i[22:0] != 0;
    a_inf = ea == 8'hFF && a_i[22:0] == 0;
    b_inf = eb == 8'hFF && b_i[22:0] == 0;
    ma = {ea != 0, a_i[22:0], 3'b0};
    mb = {eb != 0, b_i[22:0], 3'b0};
    if (ea == 0) ea = 8'd1;
    if (eb == 0) eb = 8'd1;
    swap = (eb > ea) || (eb == ea && mb > ma);
    if (swap) begin
      mbig = mb; msml = ma; el = eb; d = eb - ea;
      sbig = b_i[31]; ssml = a_i[31];
    end else begin
      mbig = ma; msml = mb; el = ea; d = ea - eb;
      sbig = a_i[31]; ssml = b_i[31];
    end
    if (d > 8'd26) begin
      al = 27'd0;
      stk = |msml;
    end else begin
      al = msml >> d;
      stk = |(msml & ~(al << d));
    end
    al[0] = al[0] | stk;
    if (sbig == ssml) sum_d = {1'b0, mbig} + {1'b0, al};
    else sum_d = {1'b0, mbig} - {1'b0, al};
    sgn_d = sbig;
    exp_d = el;
    zero_d = (sum_d == 0);
    spec_d = 1'b1;
    if (a_nan || b_nan || (a_inf && b_inf && a_i[31] != b_i[31])) spec_val_d = QNaN;
    else if (a_inf) spec_val_d = a_i;
    else if (b_inf) spec_val_d = b_i;
    else if (sum_d == 0) spec_val_d = {a_i[31] & b_i[31], 31'd0};
    else begin
      spec_d = 1'b0;
      spec_val_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    sgn_q <= sgn_d;
    spec_q <= spec_d;
    zero_q <= zero_d;
    spec_val_q <= spec_val_d;
    exp_q <= exp_d;
  end

  logic [4:0] lz;
  logic found;
  logic [27:0] n;
  logic [9:0] e;
  logic [4:0] sh;
  logic [24:0] mr;
  logic g, st;

  always_comb begin
    lz = 5'd0;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && sum_q[i]) found = 1'b1;
      else if (!found) lz = lz + 5'd1;
    end
    // Bit 26 is the unit position for an exponent of exp_q.
    n = sum_q;
    e = {2'b0, exp_q};
    if (sum_q[27]) begin
      n = {1'b0, sum_q[27:2], sum_q[1] | sum_q[0]};
      e = e + 10'd1;
    end else if (lz > 5'd1) begin
      sh = lz - 5'd1;
      if (10'(sh) >= e) sh = 5'(e - 10'd1);
      n = sum_q << sh;
      e = e - 10'(sh);
    end
    sh = 5'd0;
    if (!n[26]) e = 10'd0;
    g = n[2];
    st = n[1] | n[0];
    mr = {1'b0, n[26:3]} + 25'(g && (st || n[3]));
    if (mr[24]) begin
      mr = mr >> 1;
      e = e + 10'd1;
    end else if (e == 0 && mr[23]) e = 10'd1;
    if (spec_q) s_o = spec_val_q;
    else if (e >= 10'd255) s_o = {sgn_q, 8'hFF, 23'd0};
    else s_o = {sgn_q, e[7:0], mr[22:0]};
    if (zero_q && sh != 0) s_o = '0;
  end
endmodule

// File: sv/fmma_back.sv
module fmma_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  fmma_pkg::cmd_t q_cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [31:0]    res_data_o,
  output logic           res_oor_o
);
  import fmma_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRead, StLoad, StFetch, StStep, StStore
  } state_e;

  // Each MAC step waits for the store read, two multiplier stages and two adder stages.
  localparam int unsigned StepLat = 5;
  localparam int unsigned LatW = $clog2(StepLat + 1);

  logic [31:0] mem_a [MaxDim*MaxDim];
  logic [31:0] mem_b [MaxDim*MaxDim];
  logic [31:0] mem_c [MaxDim*MaxDim];

  state_e state_q;
  logic [IdxW-1:0] i_q, j_q, k_q;
  logic [DimW-1:0] dim_q;
  logic [LatW-1:0] lat_q;
  logic [31:0] acc_q, a_rd_q, b_rd_q, c_rd_q, prod_q;
  logic [31:0] prod, sum;
  logic out_v_q, out_oor_q;
  logic [31:0] out_d_q;
  logic take;
  logic c_we;
  logic [AddrW-1:0] c_wa, c_ra;
  logic [31:0] c_wd;

  assign q_ready_o = (state_q == StIdle) && !out_v_q;
  assign take = q_valid_i && q_ready_o;

  fmma_fpmul u_mul (.clk_i(clk_i), .a_i(a_rd_q), .b_i(b_rd_q), .p_o(prod));
  always_ff @(posedge clk_i) prod_q <= canon(prod);
  fmma_fpadd u_add (.clk_i(clk_i), .a_i(acc_q), .b_i(prod_q), .s_o(sum));

  always_comb begin
    c_we = 1'b0;
    c_wa = q_cmd_i.addr;
    c_wd = q_cmd_i.value;
    c_ra = q_cmd_i.addr;
    if (take && q_cmd_i.cmd == CmdWriteC && !q_cmd_i.oor) c_we = 1'b1;
    if (state_q == StStore) begin
      c_we = 1'b1;
      c_wa = {i_q, j_q};
      c_wd = acc_q;
    end
    if (state_q != StIdle) c_ra = {i_q, j_q};
  end

  always_ff @(posedge clk_i) begin
    if (take && q_cmd_i.cmd == CmdWriteA && !q_cmd_i.oor) mem_a[q_cmd_i.addr] <= q_cmd_i.value;
    if (take && q_cmd_i.cmd == CmdWriteB && !q_cmd_i.oor) mem_b[q_cmd_i.addr] <= q_cmd_i.value;
    if (c_we) mem_c[c_wa] <= c_wd;
    c_rd_q <= mem_c[c_ra];
    a_rd_q <= mem_a[{i_q, k_q}];
    b_rd_q <= mem_b[{k_q, j_q}];
  end

  // Each step waits out the full operator latency because c depends on the previous sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      out_oor_q <= 1'b0;
      out_d_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      dim_q <= '0;
      lat_q <= '0;
      acc_q <= '0;
    end else begin
      if (out_v_q && res_ready_i) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (take) begin
            out_oor_q <= q_cmd_i.oor;
            out_d_q <= '0;
            if (q_cmd_i.cmd == CmdReadC && !q_cmd_i.oor) begin
              state_q <= StRead;
            end else if (q_cmd_i.cmd == CmdMac && q_cmd_i.dim != '0) begin
              dim_q <= q_cmd_i.dim;
              i_q <= '0;
              j_q <= '0;
              k_q <= '0;
              state_q <= StLoad;
            end else begin
              out_v_q <= 1'b1;
            end
          end
        end
        StRead: begin
          out_d_q <= c_rd_q;
          out_v_q <= 1'b1;
          state_q <= StIdle;
        end
        StLoad: state_q <= StFetch;
        StFetch: begin
          acc_q <= c_rd_q;
          lat_q <= '0;
          state_q <= StStep;
        end
        StStep: begin
          if (lat_q == LatW'(StepLat)) begin
            acc_q <= canon(sum);
            lat_q <= '0;
            if (DimW'(k_q) == dim_q - 1'b1) state_q <= StStore;
            else k_q <= k_q + 1'b1;
          end else begin
            lat_q <= lat_q + 1'b1;
          end
        end
        StStore: begin
          k_q <= '0;
          if (DimW'(j_q) == dim_q - 1'b1) begin
            j_q <= '0;
            if (DimW'(i_q) == dim_q - 1'b1) begin
              i_q <= '0;
              out_v_q <= 1'b1;
              state_q <= StIdle;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= StLoad;
            end
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= StLoad;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_valid_o = out_v_q;
  assign res_data_o = out_d_q;
  assign res_oor_o = out_oor_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_ready_i |=> out_v_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> state_q == StIdle && !out_v_q) else $error("accept while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_oor_q && out_v_q |-> out_d_q == '0) else $error("data on range error");
endmodule

// File: sv/float_matrix_multiply_accumulate_core.sv
// Element writes and unused ops give their result after the back end takes them, reads of C
// after a read state; the back end takes a new command only when idle and its last result
// is taken, and a queue of four commands decouples input from execution.
// Multiply-accumulate presents its result once every element of C is updated, set by the wait
// on the two-stage multiplier and two-stage adder in each step.
// Reset clears control state and sets the size to 32; the matrix stores stay undefined.
module float_matrix_multiply_accumulate_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] op, [7:3] row, [12:8] col, [44:13] value, [47:45] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data
  output logic [31:0] m_axis_tdata,
  // [0] out_of_range
  output logic        m_axis_tuser
);
  import fmma_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  fmma_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tdata[2:0]), .in_row_i(s_axis_tdata[7:3]),
    .in_col_i(s_axis_tdata[12:8]), .in_value_i(s_axis_tdata[44:13]),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  fmma_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_data_o(m_axis_tdata), .res_oor_o(m_axis_tuser)
  );
endmodule
